### rtl/cltab_pkg.sv
package cltab_pkg;

   localparam int CAPACITY = 16;

   localparam logic [2:0] CMD_PUT_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUT_END   = 3'd1;
   localparam logic [2:0] CMD_PUT_BEFORE = 3'd2;
   localparam logic [2:0] CMD_DELETE    = 3'd3;
   localparam logic [2:0] CMD_SEARCH    = 3'd4;
   localparam logic [2:0] CMD_DUMP      = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_KEY   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

### rtl/circular_list_table_engine.sv
// insert front/end: S_ALLOC, S_LINK, then S_OUT; empty, full or unused command: S_OUT only
// key commands read one entry a cycle in S_CMP: on a match search goes to S_OUT, delete
// to S_DEL, insert before to S_ALLOC and S_LINK; no match after used_count entries: S_OUT
// dump: each entry is read in S_DRD and sent from S_DOUT, which waits while rsp_stall holds
// one request at a time; the next is taken once the response register is loaded
// synchronous active-high reset empties the list and refills the free stack in S_INIT
module circular_list_table_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_position,
   output logic signed [31:0] rsp_entry_value,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_last
);
   localparam int CAPACITY = cltab_pkg::CAPACITY;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_CMP = 4'd3,
      S_LINK = 4'd4, S_OUT = 4'd5, S_WAIT = 4'd6, S_DRD = 4'd7, S_DOUT = 4'd8,
      S_DEL = 4'd9, S_ALLOC = 4'd10;

   logic [31:0]   vmem [CAPACITY];
   logic [AW-1:0] lmem [CAPACITY];
   logic [AW-1:0] fmem [CAPACITY];

   logic [3:0]    state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [31:0]   val_ff, val_in, key_ff, key_in;
   logic [CW-1:0] ftop_ff, ftop_in, used_ff, used_in, idx_ff, idx_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic [1:0]    st_ff, st_in;
   logic [4:0]    pos_ff, pos_in;
   logic          rv_ff, rv_in;
   logic [1:0]    ost_ff, ost_in;
   logic [4:0]    opos_ff, opos_in, ocnt_ff, ocnt_in;
   logic [31:0]   oval_ff, oval_in;
   logic          olast_ff, olast_in;

   logic          vwe, lwe, lwe2, fwe;
   logic [AW-1:0] va, la, lwa, lwd, lwa2, lwd2, fa, fwd;
   logic [31:0]   vwd, vq;
   logic [AW-1:0] lq, fq;
   logic          full;

   always_ff @(posedge clock) begin
      if (vwe) vmem[va] <= vwd;
      vq <= vmem[va];
      if (lwe) lmem[lwa] <= lwd;
      if (lwe2) lmem[lwa2] <= lwd2;
      lq <= lmem[la];
      if (fwe) fmem[fa] <= fwd;
      fq <= fmem[fa];
   end

   assign full = (used_ff >= CAP) || (ftop_ff == '0);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = ost_ff;
   assign rsp_position = opos_ff;
   assign rsp_entry_value = oval_ff;
   assign rsp_entry_count = ocnt_ff;
   assign rsp_last = olast_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; val_in = val_ff; key_in = key_ff;
      ftop_in = ftop_ff; used_in = used_ff; idx_in = idx_ff;
      head_in = head_ff; tail_in = tail_ff; prev_in = prev_ff; cur_in = cur_ff;
      st_in = st_ff; pos_in = pos_ff;
      rv_in = rv_ff && rsp_stall;
      ost_in = ost_ff; opos_in = opos_ff; oval_in = oval_ff; ocnt_in = ocnt_ff;
      olast_in = olast_ff;
      vwe = 1'b0; vwd = val_ff; va = cur_ff;
      lwe = 1'b0; lwa = cur_ff; lwd = head_ff;
      lwe2 = 1'b0; lwa2 = tail_ff; lwd2 = cur_ff;
      la = cur_ff;
      fwe = 1'b0; fa = AW'(ftop_ff - 1'b1); fwd = cur_ff;
      case (state_ff)
         S_INIT: begin
            fwe = 1'b1; fa = idx_ff[AW-1:0]; fwd = idx_ff[AW-1:0];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CAP - 1'b1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command; val_in = req_value; key_in = req_key;
               st_in = cltab_pkg::ST_OK; pos_in = '0; idx_in = '0;
               prev_in = tail_ff; cur_in = head_ff;
               state_in = S_OUT;
               case (req_command)
                  cltab_pkg::CMD_PUT_FRONT, cltab_pkg::CMD_PUT_END:
                     if (full) st_in = cltab_pkg::ST_FULL;
                     else state_in = S_ALLOC;
                  cltab_pkg::CMD_PUT_BEFORE:
                     if (used_ff == '0) st_in = cltab_pkg::ST_EMPTY;
                     else if (full) st_in = cltab_pkg::ST_FULL;
                     else state_in = S_RD;
                  cltab_pkg::CMD_DELETE, cltab_pkg::CMD_SEARCH:
                     if (used_ff == '0) st_in = cltab_pkg::ST_EMPTY;
                     else state_in = S_RD;
                  cltab_pkg::CMD_DUMP:
                     if (used_ff == '0) st_in = cltab_pkg::ST_EMPTY;
                     else state_in = S_DRD;
                  default: ;
               endcase
            end
         end
         S_RD: begin
            va = cur_ff; la = cur_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (vq == key_ff) begin
               pos_in = 5'(idx_ff + 1'b1);
               if (cmd_ff == cltab_pkg::CMD_SEARCH) state_in = S_OUT;
               else if (cmd_ff == cltab_pkg::CMD_DELETE) state_in = S_DEL;
               else state_in = S_ALLOC;
            end else if (idx_ff + 1'b1 >= used_ff) begin
               st_in = cltab_pkg::ST_NO_KEY;
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
               prev_in = cur_ff; cur_in = lq;
               va = lq; la = lq;
               state_in = S_CMP;
            end
         end
         S_ALLOC: begin
            fa = AW'(ftop_ff - 1'b1);
            state_in = S_LINK;
         end
         S_LINK: begin
            vwe = 1'b1; va = fq; vwd = val_ff;
            ftop_in = ftop_ff - 1'b1;
            used_in = used_ff + 1'b1;
            lwe = 1'b1; lwa = fq;
            if (cmd_ff == cltab_pkg::CMD_PUT_BEFORE && cur_ff != head_ff) begin
               lwd = cur_ff;
               lwe2 = 1'b1; lwa2 = prev_ff; lwd2 = fq;
            end else if (used_ff == '0) begin
               lwd = fq; head_in = fq; tail_in = fq;
            end else begin
               lwd = head_ff;
               lwe2 = 1'b1; lwa2 = tail_ff; lwd2 = fq;
               if (cmd_ff == cltab_pkg::CMD_PUT_END) tail_in = fq;
               else head_in = fq;
            end
            pos_in = '0;
            state_in = S_OUT;
         end
         S_DEL: begin
            // lq holds next of cur
            if (used_ff == CW'(1)) begin
               head_in = '0; tail_in = '0;
            end else if (cur_ff == head_ff) begin
               head_in = lq;
               lwe = 1'b1; lwa = tail_ff; lwd = lq;
            end else begin
               lwe = 1'b1; lwa = prev_ff; lwd = lq;
               if (cur_ff == tail_ff) tail_in = prev_ff;
            end
            if (ftop_ff < CAP) begin
               fwe = 1'b1; fa = ftop_ff[AW-1:0]; fwd = cur_ff;
               ftop_in = ftop_ff + 1'b1;
            end
            used_in = used_ff - 1'b1;
            pos_in = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; ost_in = st_ff;
               opos_in = (cmd_ff == cltab_pkg::CMD_SEARCH) ? pos_ff : '0;
               oval_in = '0; ocnt_in = 5'(used_ff); olast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DRD: begin
            va = cur_ff; la = cur_ff;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; ost_in = cltab_pkg::ST_OK; opos_in = '0;
               oval_in = vq; ocnt_in = 5'(used_ff);
               olast_in = (idx_ff + 1'b1 >= used_ff);
               idx_in = idx_ff + 1'b1; cur_in = lq;
               state_in = olast_in ? S_IDLE : S_DRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; ftop_ff <= CAP; used_ff <= '0; idx_ff <= '0;
         head_ff <= '0; tail_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ftop_ff <= ftop_in; used_ff <= used_in;
         idx_ff <= idx_in; head_ff <= head_in; tail_ff <= tail_in; rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in; val_ff <= val_in; key_ff <= key_in;
      prev_ff <= prev_in; cur_ff <= cur_in;
      st_ff <= st_in; pos_ff <= pos_in;
      ost_ff <= ost_in; opos_ff <= opos_in; oval_ff <= oval_in;
      ocnt_ff <= ocnt_in; olast_ff <= olast_in;
   end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int CAP = cltab_pkg::CAPACITY;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] value;
      logic [31:0] key;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  position;
      logic [31:0] entry_value;
      logic [4:0]  entry_count;
      logic        last;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = '0;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_key = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [4:0] rsp_position;
   logic signed [31:0] rsp_entry_value;
   logic [4:0] rsp_entry_count;
   logic rsp_last;

   circular_list_table_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_value(req_value), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_position(rsp_position), .rsp_entry_value(rsp_entry_value),
      .rsp_entry_count(rsp_entry_count), .rsp_last(rsp_last)
   );

   // list shadow kept as a plain ordered array
   logic [31:0] list_vals[$];
   request_type pending_reqs[$];
   response_type expected_rsps[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int hold_count = 0;
   int long_hold = 0;
   bit long_done = 0;
   int rsp_taken = 0;
   logic accepted_flag = 1'b0;
   int send_gap = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int find_entry(logic [31:0] k);
      for (int i = 0; i < list_vals.size(); i++)
         if (list_vals[i] == k) return i;
      return -1;
   endfunction

   function automatic response_type make_rsp(logic [1:0] st, logic [4:0] pos, logic [31:0] ev,
                                             logic l);
      response_type r;
      r.status = st;
      r.position = pos;
      r.entry_value = ev;
      r.entry_count = 5'(list_vals.size());
      r.last = l;
      return r;
   endfunction

   task automatic predict_list_op(request_type rq);
      int n;
      int idx;
      logic [1:0] st;
      logic [4:0] pos;
      n = list_vals.size();
      st = cltab_pkg::ST_OK;
      pos = '0;
      case (rq.command)
         cltab_pkg::CMD_PUT_FRONT, cltab_pkg::CMD_PUT_END: begin
            if (n >= CAP) st = cltab_pkg::ST_FULL;
            else if (rq.command == cltab_pkg::CMD_PUT_FRONT) list_vals.push_front(rq.value);
            else list_vals.push_back(rq.value);
         end
         cltab_pkg::CMD_PUT_BEFORE: begin
            idx = find_entry(rq.key);
            if (n == 0) st = cltab_pkg::ST_EMPTY;
            else if (n >= CAP) st = cltab_pkg::ST_FULL;
            else if (idx < 0) st = cltab_pkg::ST_NO_KEY;
            else list_vals.insert(idx, rq.value);
         end
         cltab_pkg::CMD_DELETE: begin
            idx = find_entry(rq.key);
            if (n == 0) st = cltab_pkg::ST_EMPTY;
            else if (idx < 0) st = cltab_pkg::ST_NO_KEY;
            else list_vals.delete(idx);
         end
         cltab_pkg::CMD_SEARCH: begin
            idx = find_entry(rq.key);
            if (n == 0) st = cltab_pkg::ST_EMPTY;
            else if (idx < 0) st = cltab_pkg::ST_NO_KEY;
            else pos = 5'(idx + 1);
         end
         cltab_pkg::CMD_DUMP: begin
            if (n == 0) st = cltab_pkg::ST_EMPTY;
            else begin
               for (int i = 0; i < n; i++)
                  expected_rsps.push_back(make_rsp(cltab_pkg::ST_OK, '0, list_vals[i],
                                                   i == n - 1));
               return;
            end
         end
         default: ;
      endcase
      expected_rsps.push_back(make_rsp(st, pos, '0, 1'b1));
   endtask

   // keys drawn mostly from a small pool so matches are common
   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'hffff_ffff;
         default: return 32'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [31:0] pick_key();
      if (list_vals.size() > 0 && $urandom_range(0, 3) != 0)
         return list_vals[$urandom_range(0, list_vals.size() - 1)];
      return pick_data();
   endfunction

   task automatic add_req(logic [2:0] c, logic [31:0] v, logic [31:0] k);
      request_type rq;
      rq.command = c;
      rq.value = v;
      rq.key = k;
      pending_reqs.push_back(rq);
   endtask

   always @(posedge clock) begin
      accepted_flag <= !reset && req_valid && !req_stall;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_flag) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_command <= pending_reqs[0].command;
               req_value <= pending_reqs[0].value;
               req_key <= pending_reqs[0].key;
               pending_reqs.pop_front();
               send_gap <= $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold once enough responses are taken
   always @(negedge clock) begin
      if (!long_done && rsp_taken >= 80) begin
         long_done <= 1'b1;
         long_hold <= 200;
         rsp_stall <= 1'b1;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_stall <= 1'b1;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         hold_count <= $urandom_range(0, 3);
         rsp_stall <= 1'b0;
      end else rsp_stall <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      response_type got;
      response_type exp_rsp;
      bit active;
      if (!reset) begin
         active = 1'b0;
         if (req_valid && !req_stall) begin
            active = 1'b1;
            predict_list_op({req_command, req_value, req_key});
         end
         if (rsp_valid && !rsp_stall) begin
            active = 1'b1;
            rsp_taken <= rsp_taken + 1;
            got = {rsp_status, rsp_position, rsp_entry_value, rsp_entry_count, rsp_last};
            if (expected_rsps.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected response %h", got);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (got !== exp_rsp) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"mismatch: exp st=%0d pos=%0d val=%h cnt=%0d last=%b",
                               " / got st=%0d pos=%0d val=%h cnt=%0d last=%b"},
                        exp_rsp.status, exp_rsp.position, exp_rsp.entry_value,
                        exp_rsp.entry_count, exp_rsp.last, got.status, got.position,
                        got.entry_value, got.entry_count, got.last);
               end
            end
         end
         idle_cycles <= active ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("circular_list_table_engine verification failed");
            $finish;
         end
      end
   end

   // keys often taken from live entries so matches are common
   initial begin
      logic [2:0] c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed
      add_req(cltab_pkg::CMD_DUMP, '0, '0);
      add_req(cltab_pkg::CMD_SEARCH, '0, 32'd1);
      add_req(cltab_pkg::CMD_DELETE, '0, 32'd1);
      add_req(cltab_pkg::CMD_PUT_BEFORE, 32'd5, 32'd1);
      add_req(cltab_pkg::CMD_PUT_END, 32'h8000_0000, '0);
      add_req(cltab_pkg::CMD_PUT_FRONT, 32'h7fff_ffff, '0);
      add_req(cltab_pkg::CMD_PUT_BEFORE, 32'hffff_ffff, 32'h7fff_ffff);
      add_req(cltab_pkg::CMD_PUT_BEFORE, 32'd0, 32'h8000_0000);
      add_req(cltab_pkg::CMD_PUT_BEFORE, 32'd9, 32'h1234_5678);
      add_req(cltab_pkg::CMD_SEARCH, '0, 32'h8000_0000);
      add_req(cltab_pkg::CMD_SEARCH, '0, 32'd77);
      add_req(cltab_pkg::CMD_DUMP, '0, '0);
      add_req(3'd6, 32'hffff_ffff, 32'hffff_ffff);
      add_req(3'd7, '0, '0);
      add_req(cltab_pkg::CMD_DELETE, '0, 32'hffff_ffff);
      add_req(cltab_pkg::CMD_DELETE, '0, 32'h8000_0000);
      add_req(cltab_pkg::CMD_DELETE, '0, 32'd42);
      for (int i = 0; i < 14; i++) add_req(cltab_pkg::CMD_PUT_END, 32'(i), '0);
      add_req(cltab_pkg::CMD_PUT_FRONT, 32'd100, '0);
      add_req(cltab_pkg::CMD_PUT_BEFORE, 32'd1, 32'd3);
      add_req(cltab_pkg::CMD_DUMP, '0, '0);
      add_req(cltab_pkg::CMD_DELETE, '0, 32'd0);
      add_req(cltab_pkg::CMD_DELETE, '0, 32'h7fff_ffff);
      while (pending_reqs.size() > 0) @(posedge clock);
      for (int i = 0; i < 6; i++) add_req(cltab_pkg::CMD_SEARCH, '0, 32'(i));
      // random
      for (int i = 0; i < 380; i++) begin
         while (pending_reqs.size() > 4) @(posedge clock);
         c = 3'($urandom_range(0, 7));
         if (c > cltab_pkg::CMD_DUMP && $urandom_range(0, 3) != 0) c = 3'($urandom_range(0, 3));
         add_req(c, pick_data(), pick_key());
      end
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("circular_list_table_engine verification clean");
      else
         $display("circular_list_table_engine verification failed");
      $finish;
   end

endmodule

### filelist.f
rtl/cltab_pkg.sv
rtl/circular_list_table_engine.sv
tb/sv/testbench.sv
